[hdl/kmf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package kmf_pkg;

   localparam int CP_W = 21;
   localparam logic [CP_W-1:0] MASK_CP = 21'd42;

   // command codes of an input beat
   localparam logic [1:0] CMD_ADD  = 2'd0;
   localparam logic [1:0] CMD_DEL  = 2'd1;
   localparam logic [1:0] CMD_TEXT = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_CHAR    = 2'd0;
   localparam logic [1:0] KIND_STATUS  = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_TOO_LONG = 2'd2;
   localparam logic [1:0] ST_NOT_FND  = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_SCAN,
      S_DEC,
      S_EMIT
   } state_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic cmp_en;
      logic text_mode;
      logic ins;
      logic del;
   } cell_ctl_type;

endpackage
`default_nettype wire

[hdl/kmf_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module kmf_cell
   import kmf_pkg::*;
#(
   parameter int MAX_WORD_LEN = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cell_ctl_type                  ctl,
   input  wire logic [MAX_WORD_LEN*CP_W-1:0]  key,
   input  wire logic [$clog2(MAX_WORD_LEN+2)-1:0] key_len,
   input  wire logic [$clog2(MAX_WORD_LEN+2)-1:0] best_in,
   input  wire logic                          found_in,
   input  wire logic                          free_in,
   output logic [$clog2(MAX_WORD_LEN+2)-1:0]  best_out,
   output logic                               found_out,
   output logic                               free_out
);

   localparam int LW = $clog2(MAX_WORD_LEN + 2);

   // word stored newest-first, so position j lines up with window slot j
   logic [CP_W-1:0] word_ff [MAX_WORD_LEN];
   logic [LW-1:0]   len_ff;
   logic            match_ff;
   logic [LW-1:0]   best_ff;
   logic            found_ff;
   logic            free_ff;

   logic [MAX_WORD_LEN-1:0] pos_ok;
   logic                    len_ok;
   logic                    match_in;
   logic                    first_free;

   // per-position compare against the broadcast key
   always_comb begin
      for (int j = 0; j < MAX_WORD_LEN; j++) begin
         pos_ok[j] = (word_ff[j] == key[j*CP_W +: CP_W]) || (LW'(j) >= len_ff);
      end
      len_ok     = ctl.text_mode ? (len_ff <= key_len) : (len_ff == key_len);
      match_in   = (len_ff != '0) && len_ok && (&pos_ok);
      first_free = (len_ff == '0) && !free_in;
   end

   // entry length and compare result
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         match_ff <= 1'b0;
      end else begin
         if (ctl.cmp_en) begin
            match_ff <= match_in;
         end
         if (ctl.ins && first_free) begin
            len_ff <= key_len;
         end else if (ctl.del && match_ff) begin
            len_ff <= '0;
         end
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (ctl.ins && first_free) begin
         for (int j = 0; j < MAX_WORD_LEN; j++) begin
            word_ff[j] <= key[j*CP_W +: CP_W];
         end
      end
   end

   // chain stage: running longest hit, any exact hit, any empty entry
   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff  <= '0;
         found_ff <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         best_ff  <= (match_ff && (len_ff > best_in)) ? len_ff : best_in;
         found_ff <= found_in | match_ff;
         free_ff  <= free_in | (len_ff == '0);
      end
   end

   assign best_out  = best_ff;
   assign found_out = found_ff;
   assign free_out  = free_ff;

endmodule
`default_nettype wire

[hdl/keyword_mask_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  direction  ports
// req      in         req_valid/req_ready, req_command, req_codepoint, req_last
// rsp      out        rsp_valid/rsp_ready, rsp_kind, rsp_out_codepoint, rsp_masked,
//                     rsp_status, rsp_any_match, rsp_run_end
// csr      in         csr_we, csr_wdata (replace_mode)
//
// a word beat that is not last is taken while the sequencer stays in S_IDLE; any
// other beat goes through S_CMP, S_SCAN and S_DEC, and S_EMIT puts out held text
// characters; S_SCAN waits on the cell chain that carries the longest hit and the
// lookup flags one cell per cycle; a status or verdict beat is sent from S_DEC.
// reset is synchronous; it empties the dictionary and sets replace mode.
// a stalled rsp holds the sequencer; req_ready is low while a beat is in work.
module keyword_mask_filter
   import kmf_pkg::*;
#(
   parameter int MAX_WORD_LEN = 16,
   parameter int DICT_ENTRIES = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [1:0]      req_command,
   input  wire logic [CP_W-1:0] req_codepoint,
   input  wire logic            req_last,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [CP_W-1:0]      rsp_out_codepoint,
   output logic                 rsp_masked,
   output logic [1:0]           rsp_status,
   output logic                 rsp_any_match,
   output logic                 rsp_run_end,
   input  wire logic            csr_we,
   input  wire logic            csr_wdata
);

   localparam int LW = $clog2(MAX_WORD_LEN + 2);
   localparam int IW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam int CW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;

   state_type state_ff, state_in;

   logic [CP_W-1:0] win_ff  [MAX_WORD_LEN];
   logic [CP_W-1:0] wbuf_ff [MAX_WORD_LEN];
   logic            win_shift, wbuf_shift;

   logic [LW-1:0] tpos_ff, tpos_in;
   logic [LW-1:0] pend_ff, pend_in;
   logic [LW-1:0] wfill_ff, wfill_in;
   logic          matched_ff, matched_in;
   logic          mode_ff, mode_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic          last_ff, last_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [LW-1:0] best_ff, best_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] lo_ff, lo_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      kind_ff, kind_in;
   logic [CP_W-1:0] ocp_ff, ocp_in;
   logic            masked_ff, masked_in;
   logic [1:0]      status_ff, status_in;
   logic            any_ff, any_in;
   logic            end_ff, end_in;

   cell_ctl_type ctl;
   logic [MAX_WORD_LEN*CP_W-1:0] key;
   logic [LW-1:0]                key_len;

   logic [LW-1:0] best_ch  [DICT_ENTRIES+1];
   logic          found_ch [DICT_ENTRIES+1];
   logic          free_ch  [DICT_ENTRIES+1];

   logic          accept, out_free, matched_new, off_masked;
   logic [LW-1:0] held;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign held      = pend_ff + LW'(1);
   assign matched_new = matched_ff | (best_ch[DICT_ENTRIES] != '0);
   assign off_masked  = {{(LW-IW){1'b0}}, cnt_ff} < best_ff;

   // key broadcast to the cells: text window or collected word
   always_comb begin
      for (int j = 0; j < MAX_WORD_LEN; j++) begin
         key[j*CP_W +: CP_W] = (cmd_ff == CMD_TEXT) ? win_ff[j] : wbuf_ff[j];
      end
      key_len = (cmd_ff == CMD_TEXT) ? tpos_ff : wfill_ff;
   end

   assign best_ch[0]  = '0;
   assign found_ch[0] = 1'b0;
   assign free_ch[0]  = 1'b0;

   // row of dictionary cells
   for (genvar k = 0; k < DICT_ENTRIES; k++) begin : g_cell
      kmf_cell #(
         .MAX_WORD_LEN(MAX_WORD_LEN)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .key      (key),
         .key_len  (key_len),
         .best_in  (best_ch[k]),
         .found_in (found_ch[k]),
         .free_in  (free_ch[k]),
         .best_out (best_ch[k+1]),
         .found_out(found_ch[k+1]),
         .free_out (free_ch[k+1])
      );
   end

   // sequencer next state and outputs
   always_comb begin
      state_in   = state_ff;
      tpos_in    = tpos_ff;
      pend_in    = pend_ff;
      wfill_in   = wfill_ff;
      matched_in = matched_ff;
      mode_in    = mode_ff;
      cmd_in     = cmd_ff;
      last_in    = last_ff;
      scan_in    = scan_ff;
      best_in    = best_ff;
      cnt_in     = cnt_ff;
      lo_in      = lo_ff;
      win_shift  = 1'b0;
      wbuf_shift = 1'b0;
      ctl.cmp_en    = 1'b0;
      ctl.text_mode = (cmd_ff == CMD_TEXT);
      ctl.ins       = 1'b0;
      ctl.del       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      ocp_in       = ocp_ff;
      masked_in    = masked_ff;
      status_in    = status_ff;
      any_in       = any_ff;
      end_in       = end_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in  = req_command;
               last_in = req_last;
               if (req_command == CMD_ADD || req_command == CMD_DEL) begin
                  if (wfill_ff < LW'(MAX_WORD_LEN)) begin
                     wbuf_shift = 1'b1;
                     wfill_in   = wfill_ff + LW'(1);
                  end else begin
                     wfill_in = LW'(MAX_WORD_LEN + 1);
                  end
                  if (req_last) begin
                     state_in = S_CMP;
                  end
               end else if (req_command == CMD_TEXT) begin
                  win_shift = 1'b1;
                  if (tpos_ff < LW'(MAX_WORD_LEN)) begin
                     tpos_in = tpos_ff + LW'(1);
                  end
                  state_in = S_CMP;
               end
            end
         end
         S_CMP: begin
            ctl.cmp_en = 1'b1;
            scan_in    = CW'(DICT_ENTRIES - 1);
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            if (scan_ff == '0) begin
               state_in = S_DEC;
            end else begin
               scan_in = scan_ff - CW'(1);
            end
         end
         S_DEC: begin
            if (cmd_ff != CMD_TEXT) begin
               // add or delete status
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_STATUS;
                  ocp_in       = '0;
                  masked_in    = 1'b0;
                  any_in       = 1'b0;
                  end_in       = 1'b1;
                  if (wfill_ff > LW'(MAX_WORD_LEN)) begin
                     status_in = ST_TOO_LONG;
                  end else if (cmd_ff == CMD_DEL) begin
                     status_in = found_ch[DICT_ENTRIES] ? ST_OK : ST_NOT_FND;
                     ctl.del   = 1'b1;
                  end else if (found_ch[DICT_ENTRIES]) begin
                     status_in = ST_OK;
                  end else if (free_ch[DICT_ENTRIES]) begin
                     status_in = ST_OK;
                     ctl.ins   = 1'b1;
                  end else begin
                     status_in = ST_FULL;
                  end
                  wfill_in = '0;
                  state_in = S_IDLE;
               end
            end else if (!mode_ff) begin
               // check mode: verdict on the last beat only
               matched_in = matched_new;
               if (!last_ff) begin
                  state_in = S_IDLE;
               end else if (out_free) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_VERDICT;
                  ocp_in       = '0;
                  masked_in    = 1'b0;
                  status_in    = ST_OK;
                  any_in       = matched_new;
                  end_in       = 1'b1;
                  tpos_in      = '0;
                  pend_in      = '0;
                  matched_in   = 1'b0;
                  state_in     = S_IDLE;
               end
            end else begin
               matched_in = matched_new;
               best_in    = best_ch[DICT_ENTRIES];
               if (best_ch[DICT_ENTRIES] != '0 || last_ff) begin
                  cnt_in   = IW'(held - LW'(1));
                  lo_in    = '0;
                  state_in = S_EMIT;
               end else if (held > LW'(MAX_WORD_LEN - 1)) begin
                  cnt_in   = IW'(held - LW'(1));
                  lo_in    = IW'(held - LW'(1));
                  state_in = S_EMIT;
               end else begin
                  pend_in  = held;
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            // oldest held codepoint first
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_CHAR;
               ocp_in       = off_masked ? MASK_CP : win_ff[cnt_ff];
               masked_in    = off_masked;
               status_in    = ST_OK;
               any_in       = matched_ff;
               end_in       = last_ff && (cnt_ff == lo_ff);
               if (cnt_ff == lo_ff) begin
                  pend_in  = {{(LW-IW){1'b0}}, lo_ff};
                  if (last_ff) begin
                     tpos_in    = '0;
                     pend_in    = '0;
                     matched_in = 1'b0;
                  end
                  state_in = S_IDLE;
               end else begin
                  cnt_in = cnt_ff - IW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // mode write drops the text in progress
      if (csr_we) begin
         mode_in    = csr_wdata;
         tpos_in    = '0;
         pend_in    = '0;
         matched_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tpos_ff      <= '0;
         pend_ff      <= '0;
         wfill_ff     <= '0;
         matched_ff   <= 1'b0;
         mode_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tpos_ff      <= tpos_in;
         pend_ff      <= pend_in;
         wfill_ff     <= wfill_in;
         matched_ff   <= matched_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      last_ff   <= last_in;
      scan_ff   <= scan_in;
      best_ff   <= best_in;
      cnt_ff    <= cnt_in;
      lo_ff     <= lo_in;
      kind_ff   <= kind_in;
      ocp_ff    <= ocp_in;
      masked_ff <= masked_in;
      status_ff <= status_in;
      any_ff    <= any_in;
      end_ff    <= end_in;
   end

   // text window and word buffer, newest at slot 0
   always_ff @(posedge clock) begin
      if (win_shift) begin
         win_ff[0] <= req_codepoint;
         for (int j = 1; j < MAX_WORD_LEN; j++) begin
            win_ff[j] <= win_ff[j-1];
         end
      end
      if (wbuf_shift) begin
         wbuf_ff[0] <= req_codepoint;
         for (int j = 1; j < MAX_WORD_LEN; j++) begin
            wbuf_ff[j] <= wbuf_ff[j-1];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_out_codepoint = ocp_ff;
   assign rsp_masked        = masked_ff;
   assign rsp_status        = status_ff;
   assign rsp_any_match     = any_ff;
   assign rsp_run_end       = end_ff;

endmodule
`default_nettype wire
